// File: hdl/b2d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package b2d_pkg;

  // Width of the word that is converted; only the low WORD_WIDTH bits of the input are used.
  localparam int WORD_WIDTH = 64;

  // Decimal digits needed for the widest unsigned word (log10(2) ~ 0.30103).
  localparam int DIGITS = (WORD_WIDTH * 30103) / 100000 + 1;
  localparam int BCD_W  = DIGITS * 4;
  localparam int CNT_W  = (WORD_WIDTH > 1) ? $clog2(WORD_WIDTH) : 1;
  localparam int NDIG_W = $clog2(DIGITS + 1);

  // Characters.
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // Datapath actions selected by the control word.
  typedef enum logic [2:0] {
    ACT_LOAD,
    ACT_DABBLE,
    ACT_STRIP,
    ACT_SIGN,
    ACT_DIGIT
  } act_e;

  // Branch conditions tested by the sequencer.
  typedef enum logic [2:0] {
    COND_IN_ACC,
    COND_CNT_ZERO,
    COND_NO_LEAD,
    COND_SIGN_OK,
    COND_LAST_OUT
  } cond_e;

  typedef logic [2:0] step_t;

  // Program addresses.
  localparam step_t STEP_IDLE   = 3'd0;
  localparam step_t STEP_DABBLE = 3'd1;
  localparam step_t STEP_STRIP  = 3'd2;
  localparam step_t STEP_SIGN   = 3'd3;
  localparam step_t STEP_DIGIT  = 3'd4;

  // One control word: action, branch condition, target when true, target when false.
  typedef struct packed {
    act_e  act;
    cond_e cond;
    step_t jmp;
    step_t hold;
  } ctrl_t;

  // Status flags returned by the datapath.
  typedef struct packed {
    logic in_acc;
    logic cnt_zero;
    logic no_lead;
    logic sign_ok;
    logic last_out;
  } status_t;

  // Microprogram store.
  function automatic ctrl_t rom(input step_t addr);
    ctrl_t w;
    case (addr)
      STEP_IDLE:   w = '{act: ACT_LOAD,   cond: COND_IN_ACC,   jmp: STEP_DABBLE, hold: STEP_IDLE};
      STEP_DABBLE: w = '{act: ACT_DABBLE, cond: COND_CNT_ZERO, jmp: STEP_STRIP,  hold: STEP_DABBLE};
      STEP_STRIP:  w = '{act: ACT_STRIP,  cond: COND_NO_LEAD,  jmp: STEP_SIGN,   hold: STEP_STRIP};
      STEP_SIGN:   w = '{act: ACT_SIGN,   cond: COND_SIGN_OK,  jmp: STEP_DIGIT,  hold: STEP_SIGN};
      STEP_DIGIT:  w = '{act: ACT_DIGIT,  cond: COND_LAST_OUT, jmp: STEP_IDLE,   hold: STEP_DIGIT};
      default:     w = '{act: ACT_LOAD,   cond: COND_IN_ACC,   jmp: STEP_IDLE,   hold: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: hdl/b2d_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module b2d_seq (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  b2d_pkg::status_t status_i,
  output b2d_pkg::ctrl_t   ctrl_o
);

  b2d_pkg::step_t step_q, step_d;
  b2d_pkg::ctrl_t ctrl;
  logic           take;

  // Fetch the control word for the current step.
  assign ctrl   = b2d_pkg::rom(step_q);
  assign ctrl_o = ctrl;

  // Select the branch condition named by the control word.
  always_comb begin
    case (ctrl.cond)
      b2d_pkg::COND_IN_ACC:   take = status_i.in_acc;
      b2d_pkg::COND_CNT_ZERO: take = status_i.cnt_zero;
      b2d_pkg::COND_NO_LEAD:  take = status_i.no_lead;
      b2d_pkg::COND_SIGN_OK:  take = status_i.sign_ok;
      b2d_pkg::COND_LAST_OUT: take = status_i.last_out;
      default:                take = 1'b0;
    endcase
    step_d = take ? ctrl.jmp : ctrl.hold;
  end

  // Step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= b2d_pkg::STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/b2d_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module b2d_dp (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  b2d_pkg::ctrl_t                     ctrl_i,
  output b2d_pkg::status_t                   status_o,
  input  wire                                in_valid_i,
  output logic                               in_stall_o,
  input  wire  [63:0]                        value_bits_i,
  input  wire                                signed_mode_i,
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output logic [7:0]                         ascii_char_o,
  output logic                               last_char_o
);

  localparam int W = b2d_pkg::WORD_WIDTH;
  localparam int B = b2d_pkg::BCD_W;

  logic [W-1:0]                  mag_q, mag_d;
  logic [B-1:0]                  bcd_q, bcd_d, bcd_adj;
  logic                          neg_q, neg_d;
  logic [b2d_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic [b2d_pkg::NDIG_W-1:0]    ndig_q, ndig_d;
  logic                          out_valid_q, out_valid_d;
  logic [7:0]                    out_char_q, out_char_d;
  logic                          out_last_q, out_last_d;

  logic [W-1:0]                  word;
  logic                          word_neg;
  logic [3:0]                    top_digit;
  logic                          one_left;
  logic                          slot_free;
  logic                          in_acc;
  logic                          emit_last;

  assign word      = value_bits_i[W-1:0];
  assign word_neg  = signed_mode_i & word[W-1];
  assign top_digit = bcd_q[B-1 -: 4];
  assign one_left  = (ndig_q == b2d_pkg::NDIG_W'(1));
  assign slot_free = !out_valid_q || !out_stall_i;
  assign in_acc    = in_valid_i && (ctrl_i.act == b2d_pkg::ACT_LOAD);
  assign emit_last = (ctrl_i.act == b2d_pkg::ACT_DIGIT) && slot_free && one_left;

  // Input is taken only while the program waits at its load step.
  assign in_stall_o = (ctrl_i.act != b2d_pkg::ACT_LOAD);

  // Status flags for the sequencer's branches.
  assign status_o.in_acc   = in_acc;
  assign status_o.cnt_zero = (cnt_q == '0);
  assign status_o.no_lead  = (top_digit != 4'd0) || one_left;
  assign status_o.sign_ok  = !neg_q || slot_free;
  assign status_o.last_out = slot_free && one_left;

  // Add three to every BCD digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < b2d_pkg::DIGITS; i++) begin
      if (bcd_q[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
      end
    end
  end

  // Datapath actions.
  always_comb begin
    mag_d       = mag_q;
    bcd_d       = bcd_q;
    neg_d       = neg_q;
    cnt_d       = cnt_q;
    ndig_d      = ndig_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (ctrl_i.act)
      b2d_pkg::ACT_LOAD: begin
        if (in_acc) begin
          neg_d  = word_neg;
          mag_d  = word_neg ? (~word + W'(1)) : word;
          bcd_d  = '0;
          cnt_d  = b2d_pkg::CNT_W'(W - 1);
          ndig_d = b2d_pkg::NDIG_W'(b2d_pkg::DIGITS);
        end
      end
      b2d_pkg::ACT_DABBLE: begin
        bcd_d = {bcd_adj[B-2:0], mag_q[W-1]};
        mag_d = {mag_q[W-2:0], 1'b0};
        cnt_d = cnt_q - b2d_pkg::CNT_W'(1);
      end
      b2d_pkg::ACT_STRIP: begin
        if ((top_digit == 4'd0) && !one_left) begin
          bcd_d  = {bcd_q[B-5:0], 4'd0};
          ndig_d = ndig_q - b2d_pkg::NDIG_W'(1);
        end
      end
      b2d_pkg::ACT_SIGN: begin
        if (neg_q && slot_free) begin
          out_valid_d = 1'b1;
          out_char_d  = b2d_pkg::CHAR_MINUS;
          out_last_d  = 1'b0;
        end
      end
      b2d_pkg::ACT_DIGIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_char_d  = b2d_pkg::CHAR_ZERO + {4'd0, top_digit};
          out_last_d  = one_left;
          bcd_d       = {bcd_q[B-5:0], 4'd0};
          ndig_d      = ndig_q - b2d_pkg::NDIG_W'(1);
        end
      end
      default: begin
        out_valid_d = out_valid_q && out_stall_i;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    bcd_q      <= bcd_d;
    neg_q      <= neg_d;
    cnt_q      <= cnt_d;
    ndig_q     <= ndig_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign ascii_char_o = out_char_q;
  assign last_char_o  = out_last_q;

  // A delivered character is a minus sign or a decimal digit.
  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (ascii_char_o == b2d_pkg::CHAR_MINUS) ||
                    ((ascii_char_o >= b2d_pkg::CHAR_ZERO) && (ascii_char_o <= b2d_pkg::CHAR_NINE)))
    else $error("b2d_dp: illegal character on output");

  // The minus sign is never the final character.
  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (ascii_char_o == b2d_pkg::CHAR_MINUS)) |-> !last_char_o)
    else $error("b2d_dp: minus marked as last");

  // After the final digit is issued the program is back at its load step.
  a_last_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_last |=> (ctrl_i.act == b2d_pkg::ACT_LOAD) && out_valid_o && last_char_o)
    else $error("b2d_dp: sequencer did not return after last digit");

  // A new item starts with a cleared BCD accumulator.
  a_load_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (bcd_q == '0) && (ctrl_i.act == b2d_pkg::ACT_DABBLE))
    else $error("b2d_dp: load did not clear accumulator");

endmodule

`default_nettype wire

// File: hdl/binary_to_decimal_ascii.sv
// Converts one 64-bit word, read as unsigned or as two's complement according to
// signed_mode_i, into decimal ASCII text delivered one character per output item, most
// significant first, with a leading '-' for negative signed values and last_char_o set on
// the final digit; zero gives the single character '0' and the most negative signed value
// prints its full magnitude. A small microprogram steps a shift-add-3 (double dabble) unit
// once per input bit, then strips leading zero digits, then emits the sign and digits.
// The minus sign is issued within the sign step. The BCD conversion loop shifts one bit
// per cycle. One item is in work at a time; the next is accepted once the last character
// of the previous one sits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module binary_to_decimal_ascii (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [63:0] value_bits_i,
  input  wire         signed_mode_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [7:0]  ascii_char_o,
  output logic        last_char_o
);

  b2d_pkg::ctrl_t   ctrl;
  b2d_pkg::status_t status;

  // Microprogram sequencer.
  b2d_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  // Conversion datapath and output register.
  b2d_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .status_o      (status),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .value_bits_i  (value_bits_i),
    .signed_mode_i (signed_mode_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .ascii_char_o  (ascii_char_o),
    .last_char_o   (last_char_o)
  );

endmodule

`default_nettype wire
